// File: rtl/core/edf_pkg.sv
// Shared types and constants for the EDF task scheduler.
package edf_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int ID_W   = 4;

    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [DATA_W-1:0] NO_DEADLINE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] rel_dl;
        logic [DATA_W-1:0] abs_dl;
        logic [DATA_W-1:0] wait_cnt;
        logic              blocked;
    } task_entry_t;

    localparam int ENTRY_W = $bits(task_entry_t);

endpackage

// File: rtl/core/edf_req_if.sv
// Request channel of the EDF task scheduler.
interface edf_req_if;
    logic                         valid;
    logic                         ready;
    logic [edf_pkg::CMD_W-1:0]    cmd;
    logic [edf_pkg::DATA_W-1:0]   period;
    logic [edf_pkg::DATA_W-1:0]   relative_deadline;

    modport source (output valid, cmd, period, relative_deadline, input ready);
    modport sink   (input valid, cmd, period, relative_deadline, output ready);
endinterface

// File: rtl/core/edf_rsp_if.sv
// Result channel of the EDF task scheduler.
interface edf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         create_ok;
    logic [edf_pkg::ID_W-1:0]     new_task_id;
    logic                         running_valid;
    logic [edf_pkg::ID_W-1:0]     running_task;
    logic                         deadline_missed;
    logic [edf_pkg::ID_W-1:0]     missed_task;
    logic [edf_pkg::DATA_W-1:0]   tick_count;

    modport source (output valid, create_ok, new_task_id, running_valid, running_task,
                    deadline_missed, missed_task, tick_count, input ready);
    modport sink   (input valid, create_ok, new_task_id, running_valid, running_task,
                    deadline_missed, missed_task, tick_count, output ready);
endinterface

// File: rtl/core/edf_task_scheduler.sv
// Top level: earliest-deadline-first scheduler over a task table held in RAM.
//
//  channel | dir | payload                                             | accepted when
//  req     | in  | cmd, period, relative_deadline                      | valid && ready
//  rsp     | out | create_ok, new_task_id, running_valid, running_task,| valid && ready
//          |     | deadline_missed, missed_task, tick_count            |
//
//  Create: write state, then done. Unknown command: straight to done. Tick or
//  yield with nothing running: scan, then done; a yield of a running task first
//  reads, modifies and writes its entry. The scan reads one table entry per cycle.
//  Reset clears control state only; table entries are read only below task_count.
//  A request is taken in idle even while the previous result waits on rsp.ready;
//  a finished result waits in the done state until the output register frees.
module edf_task_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    edf_req_if.sink      req,
    edf_rsp_if.source    rsp
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CREATE = 3'd1;
    localparam logic [2:0] S_YRD    = 3'd2;
    localparam logic [2:0] S_YMOD   = 3'd3;
    localparam logic [2:0] S_YWR    = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    function automatic logic [edf_pkg::ID_W-1:0] to_id(input logic [IDX_W-1:0] v);
        logic [IDX_W+edf_pkg::ID_W-1:0] w;
        w = {{edf_pkg::ID_W{1'b0}}, v};
        return w[edf_pkg::ID_W-1:0];
    endfunction

    // control
    logic [2:0]       state_reg, state_next;
    logic [31:0]      tick_reg, tick_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pv_reg, pv_next;
    logic             found_reg, found_next;
    logic             scan_tick_reg, scan_tick_next;
    logic             ok_reg, ok_next;
    logic             missed_reg, missed_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic [31:0]        best_reg, best_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [IDX_W-1:0]   newid_reg, newid_next;
    logic [IDX_W-1:0]   missed_id_reg, missed_id_next;
    logic [31:0]        per_reg, per_next;
    logic [31:0]        rel_reg, rel_next;
    logic [31:0]        sum_reg, sum_next;
    edf_pkg::task_entry_t ent_reg, ent_next;
    logic               o_ok_reg, o_ok_next;
    logic [3:0]         o_newid_reg, o_newid_next;
    logic               o_run_v_reg, o_run_v_next;
    logic [3:0]         o_run_reg, o_run_next;
    logic               o_miss_reg, o_miss_next;
    logic [3:0]         o_miss_id_reg, o_miss_id_next;
    logic [31:0]        o_tick_reg, o_tick_next;

    // RAM port
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    edf_pkg::task_entry_t      ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [edf_pkg::ENTRY_W-1:0] ram_rdata;

    edf_pkg::task_entry_t ent_rd;
    logic [31:0]          wait_dec;
    logic                 blk_new;
    logic                 miss_hit;
    logic                 req_acc;

    edf_ram #(
        .WIDTH (edf_pkg::ENTRY_W),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;

    assign ent_rd   = edf_pkg::task_entry_t'(ram_rdata);
    assign wait_dec = (ent_rd.wait_cnt != 32'd0) ? (ent_rd.wait_cnt - 32'd1) : 32'd0;
    assign blk_new  = scan_tick_reg ? (ent_rd.blocked && (wait_dec != 32'd0))
                                    : ent_rd.blocked;
    assign miss_hit = scan_tick_reg && (ent_rd.abs_dl != edf_pkg::NO_DEADLINE) &&
                      (tick_reg >= ent_rd.abs_dl);

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        rd_cnt_next    = rd_cnt_reg;
        pv_next        = 1'b0;
        found_next     = found_reg;
        scan_tick_next = scan_tick_reg;
        ok_next        = ok_reg;
        missed_next    = missed_reg;
        out_valid_next = out_valid_reg;
        pidx_next      = pidx_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        newid_next     = newid_reg;
        missed_id_next = missed_id_reg;
        per_next       = per_reg;
        rel_next       = rel_reg;
        sum_next       = sum_reg;
        ent_next       = ent_reg;
        o_ok_next      = o_ok_reg;
        o_newid_next   = o_newid_reg;
        o_run_v_next   = o_run_v_reg;
        o_run_next     = o_run_reg;
        o_miss_next    = o_miss_reg;
        o_miss_id_next = o_miss_id_reg;
        o_tick_next    = o_tick_reg;

        ram_we    = 1'b0;
        ram_waddr = cur_idx_reg;
        ram_wdata = ent_rd;
        ram_raddr = cur_idx_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    per_next       = req.period;
                    rel_next       = req.relative_deadline;
                    ok_next        = 1'b0;
                    newid_next     = '0;
                    missed_next    = 1'b0;
                    missed_id_next = '0;
                    rd_cnt_next    = '0;
                    best_next      = edf_pkg::NO_DEADLINE;
                    found_next     = 1'b0;
                    pick_next      = '0;
                    case (req.cmd)
                        edf_pkg::CMD_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        edf_pkg::CMD_YIELD:
                        begin
                            scan_tick_next = 1'b0;
                            state_next     = cur_valid_reg ? S_YRD : S_SCAN;
                        end
                        edf_pkg::CMD_TICK:
                        begin
                            scan_tick_next = 1'b1;
                            tick_next      = tick_reg + 32'd1;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CREATE:
            begin
                if (count_reg < CNT_W'(TASK_SLOTS))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = count_reg[IDX_W-1:0];
                    ram_wdata.period = per_reg;
                    ram_wdata.rel_dl = rel_reg;
                    ram_wdata.abs_dl = (rel_reg == edf_pkg::NO_DEADLINE) ?
                                       edf_pkg::NO_DEADLINE : (tick_reg + rel_reg);
                    ram_wdata.wait_cnt = 32'd0;
                    ram_wdata.blocked  = 1'b0;
                    ok_next    = 1'b1;
                    newid_next = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_YRD:
            begin
                ram_raddr  = cur_idx_reg;
                state_next = S_YMOD;
            end
            S_YMOD:
            begin
                ent_next   = ent_rd;
                sum_next   = tick_reg + ent_rd.period;
                state_next = S_YWR;
            end
            S_YWR:
            begin
                ram_we             = 1'b1;
                ram_waddr          = cur_idx_reg;
                ram_wdata.period   = ent_reg.period;
                ram_wdata.rel_dl   = ent_reg.rel_dl;
                ram_wdata.abs_dl   = sum_reg + ent_reg.rel_dl;
                ram_wdata.wait_cnt = ent_reg.period;
                ram_wdata.blocked  = 1'b1;
                state_next         = S_SCAN;
            end
            S_SCAN:
            begin
                ram_raddr = rd_cnt_reg[IDX_W-1:0];
                if (rd_cnt_reg < count_reg)
                begin
                    pv_next     = 1'b1;
                    pidx_next   = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (pv_reg)
                begin
                    if (scan_tick_reg)
                    begin
                        ram_we             = 1'b1;
                        ram_waddr          = pidx_reg;
                        ram_wdata.wait_cnt = wait_dec;
                        ram_wdata.blocked  = blk_new;
                    end
                    if (miss_hit && !missed_reg)
                    begin
                        missed_next    = 1'b1;
                        missed_id_next = pidx_reg;
                    end
                    if (!blk_new && (ent_rd.abs_dl <= best_reg))
                    begin
                        best_next  = ent_rd.abs_dl;
                        pick_next  = pidx_reg;
                        found_next = 1'b1;
                    end
                end
                if ((rd_cnt_reg >= count_reg) && !pv_reg)
                begin
                    cur_valid_next = found_reg;
                    cur_idx_next   = found_reg ? pick_reg : '0;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    o_ok_next      = ok_reg;
                    o_newid_next   = to_id(newid_reg);
                    o_run_v_next   = cur_valid_reg;
                    o_run_next     = cur_valid_reg ? to_id(cur_idx_reg) : 4'd0;
                    o_miss_next    = missed_reg;
                    o_miss_id_next = to_id(missed_id_reg);
                    o_tick_next    = tick_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            rd_cnt_reg    <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            scan_tick_reg <= 1'b0;
            ok_reg        <= 1'b0;
            missed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            rd_cnt_reg    <= rd_cnt_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            scan_tick_reg <= scan_tick_next;
            ok_reg        <= ok_next;
            missed_reg    <= missed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        newid_reg     <= newid_next;
        missed_id_reg <= missed_id_next;
        per_reg       <= per_next;
        rel_reg       <= rel_next;
        sum_reg       <= sum_next;
        ent_reg       <= ent_next;
        o_ok_reg      <= o_ok_next;
        o_newid_reg   <= o_newid_next;
        o_run_v_reg   <= o_run_v_next;
        o_run_reg     <= o_run_next;
        o_miss_reg    <= o_miss_next;
        o_miss_id_reg <= o_miss_id_next;
        o_tick_reg    <= o_tick_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.create_ok       = o_ok_reg;
    assign rsp.new_task_id     = o_newid_reg;
    assign rsp.running_valid   = o_run_v_reg;
    assign rsp.running_task    = o_run_reg;
    assign rsp.deadline_missed = o_miss_reg;
    assign rsp.missed_task     = o_miss_id_reg;
    assign rsp.tick_count      = o_tick_reg;

endmodule

// File: rtl/core/edf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module edf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
